FILE: src/adaptive_background_subtractor_core_defines.svh
// Assertion macros for the background subtractor core.
`ifndef ADAPTIVE_BACKGROUND_SUBTRACTOR_CORE_DEFINES_SVH
`define ADAPTIVE_BACKGROUND_SUBTRACTOR_CORE_DEFINES_SVH

// Consequent checked in the same cycle.
`define ABS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ABS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/abs_pkg.sv
// ----------------------------------------------------------------------------
// abs_pkg
// Types, constants and arithmetic helpers of the background subtractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package abs_pkg;

	localparam logic [1:0] CFG_ALPHA_FLOOR   = 2'd0;
	localparam logic [1:0] CFG_ALPHA_CEILING = 2'd1;
	localparam logic [1:0] CFG_INIT_VARIANCE = 2'd2;

	localparam logic [15:0] ALPHA_FLOOR_RST   = 16'd655;
	localparam logic [15:0] ALPHA_CEILING_RST = 16'd6554;
	localparam logic [23:0] INIT_VARIANCE_RST = 24'd2560;

	localparam logic [17:0] TALLY_MAX   = 18'h3FFFF;
	localparam logic [23:0] SQ_LIMIT    = 24'd57600; // 225 in 16.8
	localparam logic [15:0] ALPHA_SAT   = 16'hFFFF;
	localparam logic [25:0] DIV_REM_INIT = 26'd256;  // 2^24 >> 16

	typedef struct packed {
		logic        en;
		logic        var_en;
		logic [15:0] mean;
		logic [23:0] variance;
	} wr_t;

	typedef struct packed {
		logic        last;
		logic        primed;
		logic        motion;
		logic [7:0]  pix;
		logic [15:0] mean;
		logic [23:0] variance;
		logic [23:0] sq;
		logic [25:0] rem;
		logic [15:0] quo;
		logic [15:0] alpha;
	} stage_t;

	// Two restoring-division steps; divisor is variance + 256.
	function automatic logic [41:0] div_step2(input logic [25:0] rem,
			input logic [15:0] quo, input logic [24:0] dvs);
		logic [25:0] r;
		logic [15:0] q;
		r = rem;
		q = quo;
		for (int i = 0; i < 2; i++) begin
			r = {r[24:0], 1'b0};
			if (r >= {1'b0, dvs}) begin
				r = r - {1'b0, dvs};
				q = {q[14:0], 1'b1};
			end else begin
				q = {q[14:0], 1'b0};
			end
		end
		return {r, q};
	endfunction

endpackage

`default_nettype wire

FILE: src/abs_pixel_if.sv
// ----------------------------------------------------------------------------
// abs_pixel_if
// Pixel input channel: valid, ready and the pixel item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface abs_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_value;
	logic       frame_end;

	modport source (output valid, output pixel_value, output frame_end, input ready);
	modport sink (input valid, input pixel_value, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: src/abs_result_if.sv
// ----------------------------------------------------------------------------
// abs_result_if
// Result output channel: valid, ready and the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface abs_result_if;
	logic        valid;
	logic        ready;
	logic        motion_flag;
	logic [17:0] motion_total;
	logic        last_of_frame;

	modport source (output valid, output motion_flag, output motion_total,
		output last_of_frame, input ready);
	modport sink (input valid, input motion_flag, input motion_total,
		input last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: src/abs_model_mem.sv
// ----------------------------------------------------------------------------
// abs_model_mem
// Per-pixel mean and variance memories, one read and one write port each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abs_model_mem #(
	parameter int DEPTH = 131072,
	parameter int AW    = 17
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [15:0]        rd_mean,
	output logic [23:0]        rd_variance,
	input  wire logic [AW-1:0] wr_addr,
	input  wire abs_pkg::wr_t  wr
);

	logic [15:0] mean_mem [DEPTH];
	logic [23:0] var_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_mean     <= mean_mem[rd_addr];
			rd_variance <= var_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mean_mem[wr_addr] <= wr.mean;
			if (wr.var_en) begin
				var_mem[wr_addr] <= wr.variance;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/adaptive_background_subtractor_core.sv
// ----------------------------------------------------------------------------
// adaptive_background_subtractor_core
// Running Gaussian average background subtraction on a gray pixel stream.
//
//   channel     dir  handshake      payload
//   pixel_in    in   valid/ready    pixel_value[7:0], frame_end
//   result_out  out  valid/ready    motion_flag, motion_total[17:0], last_of_frame
//   cfg         in   cfg_we         cfg_index[1:0], cfg_data[23:0]
//
// One pixel per cycle unless a stall or a pending writeback holds it; a 13-stage
// pipeline around the model memory, 8 of them for the pipelined alpha divider.
// A pixel whose model entry is still in flight waits until its writeback,
// so frames shorter than 14 pixels stall on their own model entries.
// A stalled result freezes the whole pipeline. Reset clears control only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "adaptive_background_subtractor_core_defines.svh"

module adaptive_background_subtractor_core #(
	parameter int MAX_PIXELS = 131072
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	abs_pixel_if.sink        pixel_in,
	abs_result_if.source     result_out,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int NS    = 13;

	logic [15:0] alpha_floor_q, alpha_ceiling_q;
	logic [23:0] init_var_q;
	logic [IDX_W-1:0] idx_q;
	logic primed_q;
	logic [17:0] tally_q;

	logic out_valid_q, out_motion_q, out_last_q;
	logic [17:0] out_total_q;

	logic en, hz, accept;
	logic vld_s [1:NS];
	abs_pkg::stage_t stg_s [1:NS];
	abs_pkg::stage_t stg_c [1:NS];
	logic [IDX_W-1:0] idx_s [1:NS];
	logic [32:0] pm_old_s12;
	logic [31:0] pm_new_s12;
	logic [40:0] pv_old_s12;
	logic [39:0] pv_new_s12;

	logic [15:0] rd_mean;
	logic [23:0] rd_variance;
	abs_pkg::wr_t wr;

	logic [15:0] target_c, mag_c;
	logic [31:0] magsq_c;
	logic [27:0] nine_c;
	logic mot_c;
	logic [15:0] inv_c, afl_c, alpha_c;
	logic [16:0] na_c;
	logic [33:0] sum_m_c;
	logic [41:0] sum_v_c;
	logic [17:0] tally_next_c;
	logic [41:0] div_c [3:10];

	assign en = !out_valid_q || result_out.ready;
	assign pixel_in.ready = en && !hz;
	assign accept = pixel_in.valid && pixel_in.ready;

	always_comb begin
		hz = 1'b0;
		for (int k = 1; k <= NS; k++) begin
			if (vld_s[k] && idx_s[k] == idx_q) begin
				hz = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_floor_q   <= abs_pkg::ALPHA_FLOOR_RST;
			alpha_ceiling_q <= abs_pkg::ALPHA_CEILING_RST;
			init_var_q      <= abs_pkg::INIT_VARIANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				abs_pkg::CFG_ALPHA_FLOOR:   alpha_floor_q   <= cfg_data[15:0];
				abs_pkg::CFG_ALPHA_CEILING: alpha_ceiling_q <= cfg_data[15:0];
				abs_pkg::CFG_INIT_VARIANCE: init_var_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			primed_q <= 1'b0;
		end else if (accept) begin
			if (pixel_in.frame_end) begin
				idx_q    <= '0;
				primed_q <= 1'b1;
			end else if (idx_q == IDX_W'(MAX_PIXELS - 1)) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	abs_model_mem #(
		.DEPTH(MAX_PIXELS),
		.AW   (IDX_W)
	) u_mem (
		.clk        (clk),
		.rd_en      (accept),
		.rd_addr    (idx_q),
		.rd_mean    (rd_mean),
		.rd_variance(rd_variance),
		.wr_addr    (idx_s[NS]),
		.wr         (wr)
	);

	// stage arithmetic
	always_comb begin
		target_c = {stg_s[1].pix, 8'd0};
		mag_c    = (target_c >= rd_mean) ? target_c - rd_mean : rd_mean - target_c;
		magsq_c  = mag_c * mag_c;
		nine_c   = {4'd0, stg_s[2].variance} + {1'b0, stg_s[2].variance, 3'd0};
		mot_c    = stg_s[2].primed && ({4'd0, stg_s[2].sq} > nine_c)
			&& (stg_s[2].sq > abs_pkg::SQ_LIMIT);
		inv_c    = (stg_s[10].variance == '0) ? abs_pkg::ALPHA_SAT : stg_s[10].quo;
		afl_c    = (inv_c < alpha_floor_q) ? alpha_floor_q : inv_c;
		alpha_c  = (afl_c > alpha_ceiling_q) ? alpha_ceiling_q : afl_c;
		na_c     = 17'h10000 - {1'b0, stg_s[11].alpha};
		sum_m_c  = {1'b0, pm_old_s12} + {2'd0, pm_new_s12};
		sum_v_c  = {1'b0, pv_old_s12} + {2'd0, pv_new_s12};
		for (int k = 3; k <= 10; k++) begin
			div_c[k] = abs_pkg::div_step2(stg_s[k-1].rem, stg_s[k-1].quo,
				{1'b0, stg_s[k-1].variance} + 25'd256);
		end
	end

	// next stage contents
	always_comb begin
		stg_c[1]        = '0;
		stg_c[1].pix    = pixel_in.pixel_value;
		stg_c[1].last   = pixel_in.frame_end;
		stg_c[1].primed = primed_q;
		for (int k = 2; k <= NS; k++) begin
			stg_c[k] = stg_s[k-1];
		end
		stg_c[2].mean     = rd_mean;
		stg_c[2].variance = rd_variance;
		stg_c[2].sq       = magsq_c[31:8];
		stg_c[2].rem      = abs_pkg::DIV_REM_INIT;
		stg_c[2].quo      = '0;
		for (int k = 3; k <= 10; k++) begin
			stg_c[k].rem = div_c[k][41:16];
			stg_c[k].quo = div_c[k][15:0];
		end
		stg_c[3].motion    = mot_c;
		stg_c[11].alpha    = alpha_c;
		stg_c[13].mean     = sum_m_c[31:16];
		stg_c[13].variance = sum_v_c[39:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= accept;
			for (int k = 2; k <= NS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s[1] <= idx_q;
			for (int k = 1; k <= NS; k++) begin
				stg_s[k] <= stg_c[k];
			end
			for (int k = 2; k <= NS; k++) begin
				idx_s[k] <= idx_s[k-1];
			end
			pm_old_s12 <= na_c * stg_s[11].mean;
			pm_new_s12 <= stg_s[11].alpha * {stg_s[11].pix, 8'd0};
			pv_old_s12 <= na_c * stg_s[11].variance;
			pv_new_s12 <= stg_s[11].alpha * stg_s[11].sq;
		end
	end

	// writeback and result
	always_comb begin
		wr.en       = en && vld_s[NS];
		wr.var_en   = !stg_s[NS].primed || !stg_s[NS].motion;
		wr.mean     = stg_s[NS].primed ? stg_s[NS].mean : {stg_s[NS].pix, 8'd0};
		wr.variance = stg_s[NS].primed ? stg_s[NS].variance : init_var_q;
		tally_next_c = (stg_s[NS].motion && tally_q != abs_pkg::TALLY_MAX)
			? tally_q + 1'b1 : tally_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[NS];
			if (vld_s[NS]) begin
				tally_q <= stg_s[NS].last ? '0 : tally_next_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_motion_q <= stg_s[NS].motion;
			out_last_q   <= stg_s[NS].last;
			out_total_q  <= stg_s[NS].last ? tally_next_c : '0;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.motion_flag   = out_motion_q;
	assign result_out.motion_total  = out_total_q;
	assign result_out.last_of_frame = out_last_q;

	`ABS_ASSERT_NEXT(a_idx_restart, accept && pixel_in.frame_end, idx_q == '0, "index not restarted")
	`ABS_ASSERT_SAME(a_total_zero, out_valid_q && !out_last_q, out_total_q == '0, "total off frame end")
	`ABS_ASSERT_SAME(a_stall_blocks, out_valid_q && !result_out.ready, !pixel_in.ready, "accept in stall")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the background subtractor core against a per-pixel running-average
// predictor. The first frame is eight pixels long, and every later frame is
// at most that long. A directed table comes first. Random frames follow under
// several alpha settings, with idle gaps on both sides, a long result
// stall and drains between settings.
// ----------------------------------------------------------------------------

module testbench;

	localparam int FRAME_PIX = 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [1:0] CFG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic        motion_flag;
		logic [17:0] motion_total;
		logic        last_of_frame;
	} verdict_t;

	typedef struct {
		logic [7:0]  pix;
		logic        fe;
		bit          typed;
		logic        flag;
		logic [17:0] total;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	abs_pixel_if  pixel_in();
	abs_result_if result_out();

	adaptive_background_subtractor_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_in   (pixel_in.sink),
		.result_out (result_out.source),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [15:0] floor_q = abs_pkg::ALPHA_FLOOR_RST;
	logic [15:0] ceil_q = abs_pkg::ALPHA_CEILING_RST;
	logic [23:0] init_var_q = abs_pkg::INIT_VARIANCE_RST;
	logic [15:0] mean_m [FRAME_PIX];
	logic [23:0] var_m [FRAME_PIX];
	int          pos = 0;
	bit          primed = 0;
	logic [17:0] tally = '0;

	verdict_t pending [$];
	int       errors = 0;
	int       cycles = 0;
	bit       quiet = 0;
	bit       stall_req = 0;
	logic [7:0] bgv [FRAME_PIX];

	function automatic verdict_t predict_pixel(logic [7:0] pix, logic fe);
		longint mean, vr, tgt, mag, sq, a;
		verdict_t v;
		bit motion;
		motion = 0;
		if (!primed) begin
			mean_m[pos] = {pix, 8'd0};
			var_m[pos] = init_var_q;
		end else begin
			mean = mean_m[pos];
			vr = var_m[pos];
			tgt = longint'(pix) << 8;
			mag = tgt >= mean ? tgt - mean : mean - tgt;
			sq = (mag * mag) >> 8;
			a = 64'd16777216 / (vr + 256);
			if (a > 65535) a = 65535;
			if (a < floor_q) a = floor_q;
			if (a > ceil_q) a = ceil_q;
			motion = sq > 9 * vr && sq > 225 * 256;
			mean_m[pos] = 16'(((65536 - a) * mean + a * tgt) >> 16);
			if (!motion)
				var_m[pos] = 24'(((65536 - a) * vr + a * sq) >> 16);
			else if (tally != abs_pkg::TALLY_MAX)
				tally++;
		end
		v.motion_flag = motion;
		v.motion_total = fe ? tally : '0;
		v.last_of_frame = fe;
		if (fe) begin
			pos = 0;
			tally = '0;
			primed = 1;
		end else begin
			pos++;
		end
		return v;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic cfg_write(logic [1:0] idx, logic [23:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			abs_pkg::CFG_ALPHA_FLOOR: floor_q = data[15:0];
			abs_pkg::CFG_ALPHA_CEILING: ceil_q = data[15:0];
			abs_pkg::CFG_INIT_VARIANCE: init_var_q = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// called at a falling edge; returns at a falling edge with valid still high
	task automatic send_pixel(logic [7:0] pix, logic fe, bit typed, verdict_t typed_v);
		int g;
		verdict_t v;
		g = gap_len();
		if (g > 0) begin
			pixel_in.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		pixel_in.valid <= 1'b1;
		pixel_in.pixel_value <= pix;
		pixel_in.frame_end <= fe;
		do @(posedge clk); while (!pixel_in.ready);
		v = predict_pixel(pix, fe);
		pending.push_back(typed ? typed_v : v);
		@(negedge clk);
	endtask

	task automatic send_frame(int len);
		logic [7:0] p;
		int r;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				p = 8'(int'(bgv[i]) + $urandom_range(0, 6) - 3);
			else if (r < 85)
				p = 8'($urandom_range(0, 255));
			else
				p = ~bgv[i];
			send_pixel(p, i == len - 1, 0, '0);
		end
	endtask

	// result side
	initial begin
		result_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				result_out.ready <= 1'b0;
				repeat (300) @(negedge clk);
				stall_req = 0;
			end else begin
				if (!quiet && $urandom_range(0, 99) < 3) begin
					result_out.ready <= 1'b0;
					repeat ($urandom_range(10, 40)) @(negedge clk);
				end else begin
					result_out.ready <= quiet || ($urandom_range(0, 99) < 75);
				end
			end
		end
	end

	always @(posedge clk) begin
		verdict_t exp_v;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
		if (arst_n && result_out.valid && result_out.ready) begin
			if (pending.size() == 0) begin
				$display("%0t: result with nothing expected", $realtime);
				errors++;
			end else begin
				exp_v = pending.pop_front();
				if (result_out.motion_flag !== exp_v.motion_flag) begin
					$display("%0t: motion_flag exp %0d got %0d", $realtime,
						exp_v.motion_flag, result_out.motion_flag);
					errors++;
				end
				if (result_out.motion_total !== exp_v.motion_total) begin
					$display("%0t: motion_total exp %0d got %0d", $realtime,
						exp_v.motion_total, result_out.motion_total);
					errors++;
				end
				if (result_out.last_of_frame !== exp_v.last_of_frame) begin
					$display("%0t: last_of_frame exp %0d got %0d", $realtime,
						exp_v.last_of_frame, result_out.last_of_frame);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows [$];
		verdict_t tv;
		int sent;
		pixel_in.valid = 1'b0;
		pixel_in.pixel_value = '0;
		pixel_in.frame_end = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// variance zero on the first frame: unit alpha saturates
		cfg_write(abs_pkg::CFG_INIT_VARIANCE, 24'd0);
		cfg_write(CFG_UNMAPPED, 24'hFFFFFF);

		// first frame loads the model: no motion, zero total
		rows.push_back('{8'd0, 0, 1, 0, 0});
		rows.push_back('{8'd255, 0, 1, 0, 0});
		rows.push_back('{8'd128, 0, 1, 0, 0});
		rows.push_back('{8'd0, 0, 1, 0, 0});
		rows.push_back('{8'd255, 0, 1, 0, 0});
		rows.push_back('{8'd1, 0, 1, 0, 0});
		rows.push_back('{8'd254, 0, 1, 0, 0});
		rows.push_back('{8'd77, 1, 1, 0, 0});
		// full swing is motion; equal pixels are not
		rows.push_back('{8'd255, 0, 1, 1, 0});
		rows.push_back('{8'd0, 0, 1, 1, 0});
		rows.push_back('{8'd128, 0, 1, 0, 0});
		rows.push_back('{8'd0, 0, 0, 0, 0});
		rows.push_back('{8'd255, 0, 0, 0, 0});
		rows.push_back('{8'd16, 0, 0, 0, 0});
		rows.push_back('{8'd239, 0, 0, 0, 0});
		rows.push_back('{8'd77, 1, 0, 0, 0});
		// short frames
		rows.push_back('{8'd200, 0, 0, 0, 0});
		rows.push_back('{8'd30, 1, 0, 0, 0});
		rows.push_back('{8'd90, 1, 0, 0, 0});
		rows.push_back('{8'd90, 1, 0, 0, 0});
		foreach (rows[i]) begin
			tv.motion_flag = rows[i].flag;
			tv.motion_total = rows[i].total;
			tv.last_of_frame = rows[i].fe;
			send_pixel(rows[i].pix, rows[i].fe, rows[i].typed, tv);
		end
		pixel_in.valid <= 1'b0;
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					cfg_write(abs_pkg::CFG_ALPHA_FLOOR, 24'd0);
					cfg_write(abs_pkg::CFG_ALPHA_CEILING, 24'd65535);
				end
				1: begin
					cfg_write(abs_pkg::CFG_ALPHA_FLOOR, 24'd655);
					cfg_write(abs_pkg::CFG_ALPHA_CEILING, 24'd6554);
					cfg_write(abs_pkg::CFG_INIT_VARIANCE, 24'hFFFFFF);
				end
				2: begin
					cfg_write(abs_pkg::CFG_ALPHA_FLOOR, 24'd65535);
					cfg_write(abs_pkg::CFG_ALPHA_CEILING, 24'd65535);
				end
				3: begin
					// floor above ceiling
					cfg_write(abs_pkg::CFG_ALPHA_FLOOR, 24'd40000);
					cfg_write(abs_pkg::CFG_ALPHA_CEILING, 24'd100);
				end
				4: begin
					cfg_write(abs_pkg::CFG_ALPHA_FLOOR, 24'd0);
					cfg_write(abs_pkg::CFG_ALPHA_CEILING, 24'd0);
				end
				default: begin
					cfg_write(abs_pkg::CFG_ALPHA_FLOOR, 24'($urandom_range(0, 3000)));
					cfg_write(abs_pkg::CFG_ALPHA_CEILING, 24'($urandom_range(2000, 65535)));
				end
			endcase
			quiet = ph == 3;
			if (ph == 1) stall_req = 1;
			foreach (bgv[i]) bgv[i] = 8'($urandom_range(0, 255));
			sent = 0;
			while (sent < 265) begin
				if (sent > 130 && sent < 140) begin
					pixel_in.valid <= 1'b0;
					drain();
				end
				begin
					int len;
					len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : FRAME_PIX;
					send_frame(len);
					sent += len;
				end
			end
			pixel_in.valid <= 1'b0;
			drain();
		end

		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
